// ----- hw/rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: operation codes and widths.
package rau_pkg;
    localparam int OpW   = 3;
    localparam int InW   = 16;
    localparam int NumW  = 32;
    localparam int DenW  = 31;
    localparam int WorkW = 34;   // signed working width for raw products and sums

    localparam logic [OpW-1:0] OP_ADD = 3'd0;
    localparam logic [OpW-1:0] OP_SUB = 3'd1;
    localparam logic [OpW-1:0] OP_MUL = 3'd2;
    localparam logic [OpW-1:0] OP_DIV = 3'd3;
    localparam logic [OpW-1:0] OP_CMP = 3'd4;

    typedef logic signed [WorkW-1:0] work_t;
endpackage

// ----- hw/rtl/rau_divider.sv -----
// Shared signed restoring divider, one quotient bit per cycle, truncating like C.
module rau_divider
    import rau_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  work_t dividend,
    input  work_t divisor,
    output logic  done,
    output work_t quotient,
    output work_t remainder
);
    localparam int CntW = $clog2(WorkW + 1);

    logic [WorkW-1:0] q_reg, q_next;
    logic [WorkW-1:0] r_reg, r_next;
    logic [WorkW-1:0] d_reg, d_next;
    logic             qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [WorkW:0]   shifted, diff;
    logic [WorkW-1:0] mag_a, mag_b;

    assign mag_a   = dividend[WorkW-1] ? WorkW'(-dividend) : WorkW'(dividend);
    assign mag_b   = divisor[WorkW-1] ? WorkW'(-divisor) : WorkW'(divisor);
    assign shifted = {r_reg, q_reg[WorkW-1]};
    assign diff    = shifted - {1'b0, d_reg};

    // The partial remainder stays below the divisor, so it always fits WorkW bits.
    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        qneg_next = qneg_reg; rneg_next = rneg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            q_next = mag_a; r_next = '0; d_next = mag_b;
            qneg_next = dividend[WorkW-1] ^ divisor[WorkW-1];
            rneg_next = dividend[WorkW-1];
            cnt_next = CntW'(WorkW); busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WorkW]) begin
                r_next = diff[WorkW-1:0];
                q_next = {q_reg[WorkW-2:0], 1'b1};
            end else begin
                r_next = shifted[WorkW-1:0];
                q_next = {q_reg[WorkW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        qneg_reg <= qneg_next; rneg_reg <= rneg_next; cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? work_t'(-q_reg) : work_t'(q_reg);
    assign remainder = rneg_reg ? work_t'(-r_reg) : work_t'(r_reg);
endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, multiplier and result register.
// The unit takes one item of two signed fractions and an operation code (add, subtract,
// multiply, divide, equality compare) and returns one result item. Arithmetic operations
// form the raw numerator and denominator by cross multiplication with one 16x16 multiplier
// (four products, one per cycle), then reduce by a truncating-remainder Euclid gcd whose
// remainders and the two final divisions all run on one shared 34-bit bit-serial divider.
// A compare or an error found on the operands goes from S_IDLE straight to S_DONE and
// skips the multiplier and divider, and a divide by a zero numerator is found in S_FORM
// after the products. The gcd sign is kept as found, so results are not sign-normalized.
// A zero operand denominator, a divide by zero, an unused code or a reduced value that
// does not fit its field gives status 1 with all other fields zero. s_ready is high only
// while the unit is idle and its result register is empty.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OpW-1:0]         s_req_type,
    input  logic signed [InW-1:0]  s_a_num,
    input  logic signed [InW-1:0]  s_a_den,
    input  logic signed [InW-1:0]  s_b_num,
    input  logic signed [InW-1:0]  s_b_den,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [NumW-1:0] m_res_num,
    output logic signed [DenW-1:0] m_res_den,
    output logic                   m_equal,
    output logic                   m_status
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_MUL3  = 4'd4;
    localparam logic [3:0] S_FORM  = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_GWAIT = 4'd7;
    localparam logic [3:0] S_DIVN  = 4'd8;
    localparam logic [3:0] S_NWAIT = 4'd9;
    localparam logic [3:0] S_DWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [OpW-1:0] op_reg, op_next;
    logic signed [InW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    work_t p0_reg, p0_next, p1_reg, p1_next;   // product scratch
    work_t n_reg, n_next, d_reg, d_next;       // raw numerator and denominator
    work_t x_reg, x_next, y_reg, y_next;       // Euclid pair
    work_t qn_reg, qn_next;
    logic signed [InW-1:0] ma, mb;
    logic signed [2*InW-1:0] prod_raw;
    work_t prod;
    logic  dv_start;
    work_t dv_a, dv_b, dv_q, dv_r;
    logic  dv_done;
    logic  out_valid_reg, out_valid_next;
    logic signed [NumW-1:0] onum_reg, onum_next;
    logic signed [DenW-1:0] oden_reg, oden_next;
    logic  oeq_reg, oeq_next, ost_reg, ost_next;
    logic  accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;

    // One shared 16x16 signed multiplier, operands chosen by the state.
    always_comb begin
        ma = an_reg; mb = bd_reg;
        unique case (state_reg)
            S_MUL1: begin ma = bn_reg; mb = ad_reg; end
            S_MUL2: begin ma = an_reg; mb = bn_reg; end
            S_MUL3: begin ma = ad_reg; mb = (op_reg == OP_DIV) ? bn_reg : bd_reg; end
            default: begin ma = an_reg; mb = bd_reg; end
        endcase
        prod_raw = ma * mb;
        prod = work_t'(prod_raw);
    end

    rau_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b), .done(dv_done),
        .quotient(dv_q), .remainder(dv_r)
    );

    always_comb begin
        state_next = state_reg; op_next = op_reg;
        p0_next = p0_reg; p1_next = p1_reg; n_next = n_reg; d_next = d_reg;
        x_next = x_reg; y_next = y_reg; qn_next = qn_reg;
        out_valid_next = out_valid_reg; onum_next = onum_reg; oden_next = oden_reg;
        oeq_next = oeq_reg; ost_next = ost_reg;
        dv_start = 1'b0; dv_a = x_reg; dv_b = y_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (accept) begin
                op_next = s_req_type;
                if (s_a_den == '0 || s_b_den == '0 || s_req_type > OP_CMP) begin
                    onum_next = '0; oden_next = '0; oeq_next = 1'b0; ost_next = 1'b1;
                    state_next = S_DONE;
                end else if (s_req_type == OP_CMP) begin
                    onum_next = '0; oden_next = '0; ost_next = 1'b0;
                    oeq_next = (s_a_num == s_b_num) && (s_a_den == s_b_den);
                    state_next = S_DONE;
                end else begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0: begin p0_next = prod; state_next = S_MUL1; end
            S_MUL1: begin p1_next = prod; state_next = S_MUL2; end
            S_MUL2: begin
                unique case (op_reg)
                    OP_ADD:  n_next = p0_reg + p1_reg;
                    OP_SUB:  n_next = p0_reg - p1_reg;
                    OP_MUL:  n_next = prod;
                    default: n_next = p0_reg;
                endcase
                state_next = S_MUL3;
            end
            S_MUL3: begin d_next = prod; state_next = S_FORM; end
            S_FORM: begin
                if (d_reg == '0) begin
                    onum_next = '0; oden_next = '0; oeq_next = 1'b0; ost_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    x_next = n_reg; y_next = d_reg; state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (y_reg == '0) begin
                    dv_a = n_reg; dv_b = x_reg; dv_start = 1'b1;
                    state_next = S_NWAIT;
                end else begin
                    dv_start = 1'b1; state_next = S_GWAIT;
                end
            end
            S_GWAIT: if (dv_done) begin
                x_next = y_reg; y_next = dv_r; state_next = S_GCD;
            end
            S_NWAIT: if (dv_done) begin
                qn_next = dv_q; state_next = S_DIVN;
            end
            S_DIVN: begin
                dv_a = d_reg; dv_b = x_reg; dv_start = 1'b1; state_next = S_DWAIT;
            end
            S_DWAIT: if (dv_done) begin
                oeq_next = 1'b0;
                if (qn_reg[WorkW-1:NumW-1] != {(WorkW-NumW+1){qn_reg[NumW-1]}} ||
                    dv_q[WorkW-1:DenW-1] != {(WorkW-DenW+1){dv_q[DenW-1]}}) begin
                    onum_next = '0; oden_next = '0; ost_next = 1'b1;
                end else begin
                    onum_next = qn_reg[NumW-1:0]; oden_next = dv_q[DenW-1:0];
                    ost_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE: begin out_valid_next = 1'b1; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; p0_reg <= p0_next; p1_reg <= p1_next;
        n_reg <= n_next; d_reg <= d_next; x_reg <= x_next; y_reg <= y_next;
        qn_reg <= qn_next; onum_reg <= onum_next; oden_reg <= oden_next;
        oeq_reg <= oeq_next; ost_reg <= ost_next;
        if (accept) begin
            an_reg <= s_a_num; ad_reg <= s_a_den; bn_reg <= s_b_num; bd_reg <= s_b_den;
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_res_num = onum_reg;
    assign m_res_den = oden_reg;
    assign m_equal   = oeq_reg;
    assign m_status  = ost_reg;

    // A result never claims both an equality hit and an error.
    a_eq_not_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_equal && m_status)) else $error("equal and status both set");
    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_res_num == '0 && m_res_den == '0))
        else $error("error result with nonzero fields");
    // No new item is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");
endmodule
